// File: hdl/sfc_pkg.sv
package sfc_pkg;

   // SLIP framing bytes.
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   // Operation selector codes.
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // One input byte produces at most this many results.
   localparam int RES_DEPTH = 3;
   localparam int RES_IDX_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   // Value of the skip-first-byte register after reset.
   localparam logic SKIP_FIRST_RESET = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       frame_end;
      logic       bad_escape;
   } sfc_result_type;

   typedef sfc_result_type [RES_DEPTH-1:0] sfc_result_list_type;

   typedef struct packed {
      sfc_result_list_type    res;
      logic [RES_CNT_W-1:0]   count;
   } sfc_burst_type;

endpackage

// File: hdl/sfc_core.sv
module sfc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  cmd,
   input  logic [7:0]            data_byte,
   input  logic                  array_last,
   input  logic                  skip_first_byte,
   output sfc_pkg::sfc_burst_type burst
);
   import sfc_pkg::*;

   logic at_start_ff, at_start_in;
   logic esc_pend_ff, esc_pend_in;
   logic discard_ff, discard_in;
   logic error_ff, error_in;

   // Builds the results of one byte in order and the next framing state.
   always_comb begin
      sfc_result_list_type  res;
      logic [RES_CNT_W-1:0] cnt;
      sfc_result_type       r;

      res         = '0;
      cnt         = '0;
      r           = '0;
      at_start_in = array_last;
      esc_pend_in = esc_pend_ff;
      discard_in  = discard_ff;
      error_in    = error_ff;

      if (cmd == CMD_ENCODE) begin
         if (!(at_start_ff && skip_first_byte)) begin
            r = '{out_byte: data_byte, has_byte: 1'b1, frame_end: 1'b0, bad_escape: 1'b0};
            if (data_byte == SLIP_END || data_byte == SLIP_ESC) begin
               r.out_byte = SLIP_ESC;
               res[cnt[RES_IDX_W-1:0]] = r;
               cnt = cnt + RES_CNT_W'(1);
               r.out_byte = (data_byte == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
            end
            res[cnt[RES_IDX_W-1:0]] = r;
            cnt = cnt + RES_CNT_W'(1);
         end
         if (array_last) begin
            res[cnt[RES_IDX_W-1:0]] =
               '{out_byte: SLIP_END, has_byte: 1'b1, frame_end: 1'b1, bad_escape: 1'b0};
            cnt = cnt + RES_CNT_W'(1);
         end
      end else begin
         if (!discard_ff) begin
            if (esc_pend_ff) begin
               esc_pend_in = 1'b0;
               if (data_byte == SLIP_ESC_END || data_byte == SLIP_ESC_ESC) begin
                  res[cnt[RES_IDX_W-1:0]] = '{
                     out_byte: (data_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC,
                     has_byte: 1'b1, frame_end: 1'b0, bad_escape: 1'b0};
                  cnt = cnt + RES_CNT_W'(1);
               end else begin
                  discard_in = 1'b1;
                  error_in   = 1'b1;
                  if (!array_last) begin
                     res[cnt[RES_IDX_W-1:0]] =
                        '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b0, bad_escape: 1'b1};
                     cnt = cnt + RES_CNT_W'(1);
                  end
               end
            end else if (data_byte == SLIP_ESC) begin
               esc_pend_in = 1'b1;
            end else if (data_byte != SLIP_END && !array_last) begin
               res[cnt[RES_IDX_W-1:0]] =
                  '{out_byte: data_byte, has_byte: 1'b1, frame_end: 1'b0, bad_escape: 1'b0};
               cnt = cnt + RES_CNT_W'(1);
            end
         end
         if (array_last) begin
            res[cnt[RES_IDX_W-1:0]] =
               '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, bad_escape: error_in};
            cnt = cnt + RES_CNT_W'(1);
         end
      end

      if (array_last) begin
         esc_pend_in = 1'b0;
         discard_in  = 1'b0;
         error_in    = 1'b0;
      end

      burst.res   = res;
      burst.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         esc_pend_ff <= 1'b0;
         discard_ff  <= 1'b0;
         error_ff    <= 1'b0;
      end else if (accept) begin
         at_start_ff <= at_start_in;
         esc_pend_ff <= esc_pend_in;
         discard_ff  <= discard_in;
         error_ff    <= error_in;
      end
   end

endmodule

// File: hdl/slip_frame_codec.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_cmd, req_data_byte, req_array_last
// rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_has_byte, rsp_frame_end,
//                                          rsp_bad_escape
// csr      in         csr_valid/csr_ready  csr_skip_first_byte
//
// A request transaction is turned into its zero to three results in the cycle it is
// accepted; they land in a three-entry result register and leave one per cycle
// while rsp does not stall. A byte with one result then sustains one transaction
// per cycle; a byte with more holds req until its last leaves the single rsp port.
// Reset is synchronous and active high; it empties the result register, returns the
// framing state to the start of an array and sets skip_first_byte to 1.
// A stall on rsp holds the head result steady and back-pressures req once the
// result register cannot take the next burst.
module slip_frame_codec (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_array_last,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_frame_end,
   output logic       rsp_bad_escape,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_skip_first_byte
);
   import sfc_pkg::*;

   // Configuration register; the write port is always ready.
   logic skip_ff;

   // Result register: the head entry drives rsp, the count says how many remain.
   sfc_result_list_type  res_ff, res_in;
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;

   sfc_burst_type burst;
   logic          req_take;
   logic          rsp_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= SKIP_FIRST_RESET;
      end else if (csr_valid && csr_ready) begin
         skip_ff <= csr_skip_first_byte;
      end
   end

   // The result register is about to be empty when nothing remains or the last
   // remaining result leaves in this cycle; only then is a new burst loaded.
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == '0) ||
                        (cnt_ff == RES_CNT_W'(1) && rsp_take));
   assign req_take  = req_valid && !req_stall;

   sfc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_take),
      .cmd            (req_cmd),
      .data_byte      (req_data_byte),
      .array_last     (req_array_last),
      .skip_first_byte(skip_ff),
      .burst          (burst)
   );

   // Load a fresh burst, or shift the queue down by one as the head leaves.
   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (req_take) begin
         res_in = burst.res;
         cnt_in = burst.count;
      end else if (rsp_take) begin
         for (int i = 0; i < RES_DEPTH - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         cnt_in = cnt_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_out_byte   = res_ff[0].out_byte;
   assign rsp_has_byte   = res_ff[0].has_byte;
   assign rsp_frame_end  = res_ff[0].frame_end;
   assign rsp_bad_escape = res_ff[0].bad_escape;

endmodule

// File: test/slip_frame_codec_tb.sv
`timescale 1ns / 100ps

module slip_frame_codec_tb;
   import sfc_pkg::*;

   // The receiver holds off for this many cycles once during the last phase.
   localparam int HOLD_CYCLES = 48;
   // Cycles without any accepted transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Settling time after the last expected result, before a register write or the end.
   localparam int DRAIN_CYCLES = 8;
   // Minimum count of random input bytes per random phase.
   localparam int PHASE_ITEMS = 148;

   // The scoreboard keeps its own copy of the framing state and the skip register.
   // It predicts the results of every accepted request transaction and checks
   // every accepted result transaction against the oldest prediction.
   class slip_frame_scoreboard;
      sfc_result_type slip_results_due[$];
      logic           skip_first;
      logic           at_start;
      logic           esc_pending;
      logic           discarding;
      logic           error_seen;
      int             failures;

      function new();
         skip_first  = SKIP_FIRST_RESET;
         at_start    = 1'b1;
         esc_pending = 1'b0;
         discarding  = 1'b0;
         error_seen  = 1'b0;
         failures    = 0;
      endfunction

      function void set_skip(logic value);
         skip_first = value;
      endfunction

      function int pending();
         return slip_results_due.size();
      endfunction

      function void add_due_result(logic [7:0] b, logic has, logic fend, logic bad);
         sfc_result_type r;
         r.out_byte   = b;
         r.has_byte   = has;
         r.frame_end  = fend;
         r.bad_escape = bad;
         slip_results_due.push_back(r);
      endfunction

      function void note_request(logic cmd, logic [7:0] b, logic last);
         if (cmd == CMD_ENCODE) begin
            if (!(at_start && skip_first)) begin
               if (b == SLIP_END) begin
                  add_due_result(SLIP_ESC, 1'b1, 1'b0, 1'b0);
                  add_due_result(SLIP_ESC_END, 1'b1, 1'b0, 1'b0);
               end else if (b == SLIP_ESC) begin
                  add_due_result(SLIP_ESC, 1'b1, 1'b0, 1'b0);
                  add_due_result(SLIP_ESC_ESC, 1'b1, 1'b0, 1'b0);
               end else begin
                  add_due_result(b, 1'b1, 1'b0, 1'b0);
               end
            end
            if (last)
               add_due_result(SLIP_END, 1'b1, 1'b1, 1'b0);
         end else begin
            if (!discarding) begin
               if (esc_pending) begin
                  esc_pending = 1'b0;
                  if (b == SLIP_ESC_END) begin
                     add_due_result(SLIP_END, 1'b1, 1'b0, 1'b0);
                  end else if (b == SLIP_ESC_ESC) begin
                     add_due_result(SLIP_ESC, 1'b1, 1'b0, 1'b0);
                  end else begin
                     discarding = 1'b1;
                     error_seen = 1'b1;
                     if (!last)
                        add_due_result(8'h00, 1'b0, 1'b0, 1'b1);
                  end
               end else if (b == SLIP_ESC) begin
                  esc_pending = 1'b1;
               end else if (b != SLIP_END && !last) begin
                  add_due_result(b, 1'b1, 1'b0, 1'b0);
               end
            end
            if (last)
               add_due_result(8'h00, 1'b0, 1'b1, error_seen);
         end
         if (last) begin
            at_start    = 1'b1;
            esc_pending = 1'b0;
            discarding  = 1'b0;
            error_seen  = 1'b0;
         end else begin
            at_start = 1'b0;
         end
      endfunction

      function void check_result(sfc_result_type got);
         sfc_result_type want;
         if (slip_results_due.size() == 0) begin
            if (failures < 10)
               $display("unexpected result: byte %02h has %b end %b bad %b",
                        got.out_byte, got.has_byte, got.frame_end, got.bad_escape);
            failures++;
            return;
         end
         want = slip_results_due.pop_front();
         if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
             got.frame_end !== want.frame_end || got.bad_escape !== want.bad_escape) begin
            if (failures < 10)
               $display("mismatch (byte/has/end/bad): expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                        want.out_byte, want.has_byte, want.frame_end, want.bad_escape,
                        got.out_byte, got.has_byte, got.frame_end, got.bad_escape);
            failures++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_cmd;
   logic [7:0] req_data_byte;
   logic       req_array_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_frame_end;
   logic       rsp_bad_escape;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_skip_first_byte;

   slip_frame_scoreboard sb = new();

   // Idling percentages for the two sides; phases two and three change them.
   int   send_idle_pct = 25;
   int   recv_stall_pct = 62;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   // Toggling this asks the receiver process for one long hold-off.
   logic hold_toggle = 1'b0;

   slip_frame_codec dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_data_byte       (req_data_byte),
      .req_array_last      (req_array_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_has_byte        (rsp_has_byte),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_bad_escape      (rsp_bad_escape),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_skip_first_byte (csr_skip_first_byte)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // All handshakes are sampled at the rising edge, before any nonblocking update
   // of that edge lands, so the values seen are the ones the block saw. The result
   // is checked before the new request is noted; a result accepted at this edge can
   // only come from an earlier request.
   always @(posedge clock) begin
      sfc_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.out_byte   = rsp_out_byte;
            got.has_byte   = rsp_has_byte;
            got.frame_end  = rsp_frame_end;
            got.bad_escape = rsp_bad_escape;
            sb.check_result(got);
         end
         if (req_valid && !req_stall)
            sb.note_request(req_cmd, req_data_byte, req_array_last);
         if (csr_valid && csr_ready)
            sb.set_skip(csr_skip_first_byte);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The watchdog ends a hung run.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // The receiver stalls at random, and once holds off for a long stretch that it
   // counts itself, so that the result register fills and the request side stalls.
   initial begin
      logic hold_seen;
      int   hold_left;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Offers one byte, after a random number of idle cycles, and returns at the edge
   // where the transaction is accepted. Valid stays high for the next call.
   task automatic send_item(logic cmd, logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_data_byte  <= b;
      req_array_last <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(logic cmd, logic [7:0] frame_bytes[$]);
      foreach (frame_bytes[i])
         send_item(cmd, frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Waits until every predicted result has been taken, then lets the block settle,
   // since a byte that yields no result may still be in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_skip(logic value);
      csr_valid           <= 1'b1;
      csr_skip_first_byte <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Framing bytes and the extremes come up far more often than in uniform data.
   function automatic logic [7:0] slip_biased_byte();
      case ($urandom_range(9))
         0, 1: return SLIP_END;
         2, 3: return SLIP_ESC;
         4: return SLIP_ESC_END;
         5: return SLIP_ESC_ESC;
         6: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Builds one array and sends it. Most decode arrays are well-formed SLIP frames
   // with random content; the rest are raw bytes rich in escape bytes, so that bad
   // escapes and dangling escapes occur. A few arrays mix the selector per byte.
   task automatic send_random_array();
      logic [7:0] frame_bytes[$];
      logic [7:0] raw;
      logic       arr_cmd;
      logic       cmd;
      int         kind;
      int         len;
      kind = $urandom_range(99);
      arr_cmd = ($urandom_range(1) != 0) ? CMD_DECODE : CMD_ENCODE;
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
      if (arr_cmd == CMD_DECODE && kind < 75) begin
         if ($urandom_range(4) == 0)
            frame_bytes.push_back(SLIP_END);
         repeat (len) begin
            raw = slip_biased_byte();
            if (raw == SLIP_END) begin
               frame_bytes.push_back(SLIP_ESC);
               frame_bytes.push_back(SLIP_ESC_END);
            end else if (raw == SLIP_ESC) begin
               frame_bytes.push_back(SLIP_ESC);
               frame_bytes.push_back(SLIP_ESC_ESC);
            end else begin
               frame_bytes.push_back(raw);
            end
         end
         frame_bytes.push_back(($urandom_range(4) == 0) ? slip_biased_byte() : SLIP_END);
      end else begin
         repeat (len) frame_bytes.push_back(slip_biased_byte());
      end
      foreach (frame_bytes[i]) begin
         cmd = arr_cmd;
         if (kind >= 92)
            cmd = ($urandom_range(1) != 0) ? CMD_DECODE : CMD_ENCODE;
         send_item(cmd, frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic run_random_phase(int count);
      int target;
      target = items_sent + count;
      while (items_sent < target)
         send_random_array();
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_cmd             = CMD_ENCODE;
      req_data_byte       = 8'h00;
      req_array_last      = 1'b0;
      rsp_stall           = 1'b0;
      csr_valid           = 1'b0;
      csr_skip_first_byte = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the skip register at its reset value of one.
      // The first encode byte is dropped, both framing bytes are escaped, and the
      // frame closes with an end byte.
      send_frame(CMD_ENCODE, '{8'h11, SLIP_END, SLIP_ESC, 8'h00, 8'hFF});
      // A skipped first byte that is also the last yields only the end byte.
      send_frame(CMD_ENCODE, '{8'hAB});
      // A clean frame: leading end byte dropped, both escape pairs resolved, and
      // the plain final byte taken as the terminator.
      send_frame(CMD_DECODE, '{SLIP_END, 8'h41, SLIP_ESC, SLIP_ESC_END, SLIP_ESC,
                               SLIP_ESC_ESC, 8'hFF, 8'h00});
      // A bad escape early in the array; the rest of the array is discarded.
      send_frame(CMD_DECODE, '{SLIP_ESC, 8'h55, SLIP_ESC, SLIP_END});
      // A bad escape on the last byte gives only the flagged frame end.
      send_frame(CMD_DECODE, '{SLIP_ESC, 8'h12});
      // An escape byte as the last byte emits nothing for it.
      send_frame(CMD_DECODE, '{SLIP_ESC});
      // A valid escape pair that ends on the last byte emits the resolved byte.
      send_frame(CMD_DECODE, '{SLIP_ESC, SLIP_ESC_END});
      // An encode step in the middle of a pending escape leaves the escape pending.
      send_item(CMD_DECODE, SLIP_ESC, 1'b0);
      send_item(CMD_ENCODE, SLIP_END, 1'b0);
      send_item(CMD_DECODE, SLIP_ESC_ESC, 1'b1);
      wait_idle();
      // With skipping off, the first byte of an encode array is kept.
      write_skip(1'b0);
      send_frame(CMD_ENCODE, '{SLIP_END, 8'h00});
      wait_idle();

      // Random phase one: the sender idles lightly, the receiver heavily.
      write_skip(1'b1);
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      // Random phase two: the other way round.
      send_idle_pct  = 62;
      recv_stall_pct = 25;
      write_skip(1'b0);
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      // Random phase three: neither side idles, apart from one long receiver
      // hold-off at the start while the sender keeps offering bytes.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_skip(1'b1);
      hold_toggle <= ~hold_toggle;
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      if (sb.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
hdl/sfc_pkg.sv
hdl/sfc_core.sv
hdl/slip_frame_codec.sv
test/slip_frame_codec_tb.sv
